// ===== rtl/frc_pkg.sv =====
// shared types and constants of the fenwick range counter
`default_nettype none

package frc_pkg;

   // tree geometry
   localparam int TREE_SIZE = 4096;
   localparam int SLOT_W    = $clog2(TREE_SIZE);
   localparam int WALK_W    = SLOT_W + 1;
   localparam int POS_W     = 12;
   localparam int COUNT_W   = 32;

   localparam logic [31:0] MAX_POS = 32'(TREE_SIZE - 3);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TREE_SIZE - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UP,
      ST_DOWN_HI,
      ST_DOWN_LO,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_BUMP,
      OP_ADD,
      OP_SUB
   } op_type;

   typedef struct packed {
      logic   clear;
      logic   load;
      logic   issue;
      op_type op;
      logic   start_lo;
      logic   publish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_query;
      logic inc_in_range;
      logic range_empty;
      logic up_live;
      logic dn_live;
      logic lo_needed;
      logic pend;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/frc_ctrl.sv =====
// controller state machine of the fenwick range counter
`default_nettype none

module frc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire frc_pkg::status_type status,
   output frc_pkg::cmd_type        cmd
);

   frc_pkg::state_type state_ff;
   frc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.op       = frc_pkg::OP_BUMP;
      req_stall    = 1'b1;
      unique case (state_ff)
         frc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = frc_pkg::ST_IDLE;
            end
         end
         frc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.is_query) begin
                  state_in = status.range_empty ? frc_pkg::ST_FINISH : frc_pkg::ST_DOWN_HI;
               end else if (status.inc_in_range) begin
                  state_in = frc_pkg::ST_UP;
               end
            end
         end
         frc_pkg::ST_UP: begin
            if (status.up_live) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = frc_pkg::ST_IDLE;
            end
         end
         frc_pkg::ST_DOWN_HI: begin
            cmd.op = frc_pkg::OP_ADD;
            if (status.dn_live) begin
               cmd.issue = 1'b1;
            end else if (status.lo_needed) begin
               cmd.start_lo = 1'b1;
               state_in     = frc_pkg::ST_DOWN_LO;
            end else begin
               state_in = frc_pkg::ST_FINISH;
            end
         end
         frc_pkg::ST_DOWN_LO: begin
            cmd.op = frc_pkg::OP_SUB;
            if (status.dn_live) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = frc_pkg::ST_FINISH;
            end
         end
         frc_pkg::ST_FINISH: begin
            if (!status.pend && status.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = frc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/frc_datapath.sv =====
// tree memory, walk pointer, accumulator and result register
`default_nettype none

module frc_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire frc_pkg::cmd_type              cmd,
   output frc_pkg::status_type                status,
   input  wire logic                          req_kind,
   input  wire logic [frc_pkg::POS_W-1:0]     req_first_pos,
   input  wire logic [frc_pkg::POS_W-1:0]     req_last_pos,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [frc_pkg::COUNT_W-1:0]        rsp_range_count
);

   logic [frc_pkg::COUNT_W-1:0] mem [frc_pkg::TREE_SIZE];

   logic [frc_pkg::WALK_W-1:0]  slot_ff, slot_in;
   logic [frc_pkg::WALK_W-1:0]  lo_slot_ff, lo_slot_in;
   logic                        lo_need_ff, lo_need_in;
   logic                        pend_ff, pend_in;
   frc_pkg::op_type             pend_op_ff, pend_op_in;
   logic [frc_pkg::SLOT_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [frc_pkg::COUNT_W-1:0] q_ff;
   logic [frc_pkg::COUNT_W-1:0] acc_ff, acc_in;
   logic [frc_pkg::SLOT_W-1:0]  clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [frc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [31:0]                 first_ext, last_ext, first_cl, last_cl;
   logic [frc_pkg::WALK_W-1:0]  low_bit;
   logic [frc_pkg::SLOT_W-1:0]  rd_addr;
   logic                        bump_wr;

   // request decode and clamping
   always_comb begin
      first_ext = 32'(req_first_pos);
      last_ext  = 32'(req_last_pos);
      first_cl  = (first_ext > frc_pkg::MAX_POS) ? frc_pkg::MAX_POS : first_ext;
      last_cl   = (last_ext > frc_pkg::MAX_POS) ? frc_pkg::MAX_POS : last_ext;
   end

   assign low_bit = slot_ff & (~slot_ff + frc_pkg::WALK_W'(1));
   assign rd_addr = slot_ff[frc_pkg::SLOT_W-1:0];
   assign bump_wr = pend_ff && (pend_op_ff == frc_pkg::OP_BUMP);

   always_comb begin
      slot_in      = slot_ff;
      lo_slot_in   = lo_slot_ff;
      lo_need_in   = lo_need_ff;
      pend_in      = cmd.issue;
      pend_op_in   = cmd.op;
      pend_addr_in = rd_addr;
      acc_in       = acc_ff;
      clr_in       = cmd.clear ? clr_ff + frc_pkg::SLOT_W'(1) : clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;

      // fold in the cell read last cycle
      if (pend_ff) begin
         unique case (pend_op_ff)
            frc_pkg::OP_ADD: acc_in = acc_ff + q_ff;
            frc_pkg::OP_SUB: acc_in = acc_ff - q_ff;
            default:         acc_in = acc_ff;
         endcase
      end

      if (cmd.load) begin
         acc_in     = '0;
         lo_need_in = (req_first_pos != '0);
         lo_slot_in = frc_pkg::WALK_W'(first_cl + 32'd1);
         slot_in    = req_kind ? frc_pkg::WALK_W'(last_cl + 32'd2)
                               : frc_pkg::WALK_W'(first_ext + 32'd2);
      end else if (cmd.start_lo) begin
         slot_in = lo_slot_ff;
      end else if (cmd.issue) begin
         slot_in = (cmd.op == frc_pkg::OP_BUMP) ? slot_ff + low_bit : slot_ff - low_bit;
      end

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      lo_slot_ff   <= lo_slot_in;
      lo_need_ff   <= lo_need_in;
      pend_op_ff   <= pend_op_in;
      pend_addr_ff <= pend_addr_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   // tree store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (bump_wr) begin
         mem[pend_addr_ff] <= q_ff + frc_pkg::COUNT_W'(1);
      end
      if (cmd.issue) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      status              = '0;
      status.clear_last   = (clr_ff == frc_pkg::LAST_SLOT);
      status.is_query     = req_kind;
      status.inc_in_range = (first_ext <= frc_pkg::MAX_POS);
      status.range_empty  = (req_last_pos < req_first_pos);
      status.up_live      = (slot_ff != '0) && (32'(slot_ff) < 32'(frc_pkg::TREE_SIZE));
      status.dn_live      = (slot_ff != '0);
      status.lo_needed    = lo_need_ff;
      status.pend         = pend_ff;
      status.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_count = rsp_count_ff;

   a_no_clear_in_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !pend_ff && !cmd.issue)
      else $error("clearing pass overlaps a tree walk");

   a_bump_no_collision: assert property (@(posedge clock) disable iff (reset)
      bump_wr && cmd.issue |-> rd_addr != pend_addr_ff)
      else $error("bump write and next read hit the same cell");

   a_publish_settled: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !pend_ff)
      else $error("result published with a read still in flight");

   a_down_in_tree: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && cmd.op != frc_pkg::OP_BUMP |-> 32'(slot_ff) < 32'(frc_pkg::TREE_SIZE))
      else $error("downward walk left the tree");

endmodule

`default_nettype wire

// ===== rtl/fenwick_range_counter_unit.sv =====
// top level of the fenwick range counter: controller plus datapath
//
//   channel   dir  handshake              payload
//   req_      in   req_valid / req_stall  req_kind, req_first_pos, req_last_pos
//   rsp_      out  rsp_valid / rsp_stall  rsp_range_count
//
// after reset a clearing pass zeroes all TREE_SIZE (4096) cells, with req_stall high
// increment: an upward walk, one tree cell per cycle on the memory port
// query: up to two downward walks, of at most 12 and 11 cells, then the result
// one request in flight; a finished result sits in the output register until taken
// a held result only delays the next query at its final step, never the walks
`default_nettype none

module fenwick_range_counter_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_kind,
   input  wire logic [frc_pkg::POS_W-1:0] req_first_pos,
   input  wire logic [frc_pkg::POS_W-1:0] req_last_pos,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [frc_pkg::COUNT_W-1:0]    rsp_range_count
);

   // command and status between the two halves
   frc_pkg::cmd_type    cmd;
   frc_pkg::status_type status;

   // sequencer: clear pass, walk steps, result hand-off
   frc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tree memory, walk pointer and accumulator
   frc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_first_pos   (req_first_pos),
      .req_last_pos    (req_last_pos),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_count (rsp_range_count)
   );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench of the fenwick range counter: directed and random requests
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // tree geometry from the shared package
   localparam int          TREE_SIZE = frc_pkg::TREE_SIZE;
   localparam int          POS_W     = frc_pkg::POS_W;
   localparam int          COUNT_W   = frc_pkg::COUNT_W;
   localparam logic [31:0] MAX_POS   = frc_pkg::MAX_POS;

   // request kinds as carried on req_kind
   localparam logic KIND_BUMP  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   // cycles without any handshake before the run is declared hung;
   // covers the clearing pass after reset plus long random stalls
   localparam int STALL_LIMIT = 10000;
   // settle time after the last result: an increment walk may still run
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_BUMP;
   logic [POS_W-1:0]    req_first_pos = '0;
   logic [POS_W-1:0]    req_last_pos = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COUNT_W-1:0]  rsp_range_count;

   // shadow of the tree and the counts still owed by the block
   logic [COUNT_W-1:0]  tree_cells [TREE_SIZE];
   logic [COUNT_W-1:0]  expected_counts [$];

   // idle percentages of the current phase
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;

   // run statistics
   int error_count = 0;
   int bumps_sent = 0;
   int bumps_ignored = 0;
   int queries_sent = 0;
   int empty_queries = 0;
   int nonzero_counts = 0;
   int counts_checked = 0;
   int quiet_cycles = 0;

   fenwick_range_counter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_first_pos   (req_first_pos),
      .req_last_pos    (req_last_pos),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_count (rsp_range_count)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // tree shadow: upward walk for an increment, downward walk for a prefix
   // ---------------------------------------------------------------

   // slot of position p is p+2; climb by the lowest set bit
   function automatic void tree_bump(logic [POS_W-1:0] pos);
      int unsigned slot;
      slot = pos + 2;
      while (slot != 0 && slot < TREE_SIZE) begin
         tree_cells[slot] += 1;
         slot += slot & (~slot + 1);
      end
   endfunction

   // sum of cells from slot p+2 down, clearing the lowest set bit each step
   function automatic logic [COUNT_W-1:0] tree_prefix(int unsigned pos);
      int unsigned        slot;
      logic [COUNT_W-1:0] sum;
      slot = pos + 2;
      sum = '0;
      if (slot >= TREE_SIZE) begin
         slot = TREE_SIZE - 1;
      end
      while (slot != 0) begin
         sum += tree_cells[slot];
         slot -= slot & (~slot + 1);
      end
      return sum;
   endfunction

   // apply one accepted request to the shadow, queue the count a query owes
   function automatic void predict_request(logic kind, logic [POS_W-1:0] first_pos,
                                           logic [POS_W-1:0] last_pos);
      logic [31:0]        lo_pos;
      logic [31:0]        hi_pos;
      logic [COUNT_W-1:0] count;
      if (kind == KIND_BUMP) begin
         bumps_sent++;
         // positions past the last tree slot are dropped silently
         if (32'(first_pos) <= MAX_POS) begin
            tree_bump(first_pos);
         end else begin
            bumps_ignored++;
         end
      end else begin
         queries_sent++;
         // empty range is judged on the raw positions, before clamping
         if (last_pos < first_pos) begin
            count = '0;
            empty_queries++;
         end else begin
            lo_pos = (32'(first_pos) > MAX_POS) ? MAX_POS : 32'(first_pos);
            hi_pos = (32'(last_pos) > MAX_POS) ? MAX_POS : 32'(last_pos);
            count = tree_prefix(hi_pos);
            if (lo_pos != 0) begin
               count -= tree_prefix(lo_pos - 1);
            end
         end
         if (count != 0) begin
            nonzero_counts++;
         end
         expected_counts = {expected_counts, count};
      end
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // present one request, hold it until taken, then update the shadow;
   // valid stays high when the next request follows without a gap
   task automatic send_request(logic kind, logic [POS_W-1:0] first_pos,
                               logic [POS_W-1:0] last_pos);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_first_pos <= first_pos;
      req_last_pos  <= last_pos;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_request(kind, first_pos, last_pos);
   endtask

   // stop sending and wait until every owed count has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_counts.size() != 0);
   endtask

   // position picker: hot bands at both ends so counts build up, a few past the end
   function automatic logic [POS_W-1:0] pick_position();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         return POS_W'($urandom_range(MAX_POS + 1, (1 << POS_W) - 1));
      end else if (roll < 34) begin
         return POS_W'($urandom_range(0, 63));
      end else if (roll < 44) begin
         return POS_W'($urandom_range(MAX_POS - 63, MAX_POS));
      end
      return POS_W'($urandom_range(0, MAX_POS));
   endfunction

   task automatic send_random_request();
      logic             kind;
      logic [POS_W-1:0] first_pos;
      logic [POS_W-1:0] last_pos;
      logic [POS_W-1:0] swap_pos;
      kind = ($urandom_range(0, 99) < 55) ? KIND_BUMP : KIND_COUNT;
      first_pos = pick_position();
      last_pos = pick_position();
      if (kind == KIND_BUMP) begin
         // unused by increments, but still toggled
         last_pos = POS_W'($urandom());
      end else if ($urandom_range(0, 3) == 0) begin
         // narrow window; may wrap and come out reversed
         last_pos = first_pos + POS_W'($urandom_range(0, 15));
      end else if (last_pos < first_pos && $urandom_range(0, 99) < 85) begin
         // mostly well-ordered ranges, some left reversed on purpose
         swap_pos = first_pos;
         first_pos = last_pos;
         last_pos = swap_pos;
      end
      send_request(kind, first_pos, last_pos);
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // receiver stall pattern of the current phase
   always @(posedge clock) begin
      rsp_stall <= (receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct);
   end

   // compare every taken result with the oldest owed count
   always @(posedge clock) begin
      logic [COUNT_W-1:0] owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result range_count=%0d", $realtime, rsp_range_count);
            end
         end else begin
            owed = expected_counts.pop_front();
            counts_checked++;
            if (rsp_range_count !== owed) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: range_count mismatch: expected %0d, got %0d",
                           $realtime, owed, rsp_range_count);
               end
            end
         end
      end
   end

   // hang detector: any handshake on either channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d counts still owed",
                  $realtime, STALL_LIMIT, expected_counts.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // a freshly cleared tree counts nothing anywhere
   task automatic test_cleared_tree();
      send_request(KIND_COUNT, 12'd0, POS_W'(MAX_POS));
      send_request(KIND_COUNT, 12'd4095, 12'd4095);
   endtask

   // increments at the first, last and middle positions, then point and span queries
   task automatic test_edge_positions();
      send_request(KIND_BUMP, 12'd0, 12'd4095);
      send_request(KIND_BUMP, POS_W'(MAX_POS), 12'd0);
      send_request(KIND_BUMP, 12'd1, 12'd2730);
      send_request(KIND_BUMP, 12'd2047, 12'd1365);
      send_request(KIND_BUMP, 12'd2048, 12'd4095);
      send_request(KIND_BUMP, 12'd2048, 12'd0);
      send_request(KIND_COUNT, 12'd0, 12'd0);
      send_request(KIND_COUNT, POS_W'(MAX_POS), POS_W'(MAX_POS));
      send_request(KIND_COUNT, 12'd2047, 12'd2048);
      send_request(KIND_COUNT, 12'd1, POS_W'(MAX_POS - 1));
   endtask

   // increments past the end are dropped, query ends past the end are clamped
   task automatic test_out_of_range();
      send_request(KIND_BUMP, 12'd4094, 12'd0);
      send_request(KIND_BUMP, 12'd4095, 12'd4095);
      send_request(KIND_COUNT, 12'd0, 12'd4095);
      send_request(KIND_COUNT, 12'd4094, 12'd4095);
   endtask

   // last below first gives zero, whatever clamping would have done
   task automatic test_empty_ranges();
      send_request(KIND_COUNT, 12'd1, 12'd0);
      send_request(KIND_COUNT, 12'd4095, 12'd0);
      send_request(KIND_COUNT, 12'd2048, 12'd2047);
      send_request(KIND_COUNT, 12'd4095, 12'd4094);
   endtask

   // sender holds off until all counts are back, then queries the new state
   task automatic test_drain_pause();
      send_request(KIND_BUMP, 12'd5, 12'd5);
      send_request(KIND_BUMP, 12'd6, 12'd7);
      drain_results();
      send_request(KIND_COUNT, 12'd5, 12'd6);
      send_request(KIND_COUNT, 12'd0, POS_W'(MAX_POS));
      drain_results();
   endtask

   // random traffic under each idling pattern, drained between phases
   task automatic test_random_traffic();
      int unsigned sender_pct [4]   = '{0, 85, 0, 22};
      int unsigned receiver_pct [4] = '{0, 0, 85, 22};
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = sender_pct[phase];
         receiver_stall_pct = receiver_pct[phase];
         repeat (400) send_random_request();
         drain_results();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      foreach (tree_cells[i]) begin
         tree_cells[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // the clearing pass holds req_stall high; send_request waits it out
      test_cleared_tree();
      test_edge_positions();
      test_out_of_range();
      test_empty_ranges();
      test_drain_pause();
      test_random_traffic();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_counts.size() != 0) begin
         error_count++;
         $display("%0d counts never arrived", expected_counts.size());
      end
      $display("covered %0d increments (%0d past the end) and %0d range queries",
               bumps_sent, bumps_ignored, queries_sent);
      $display("%0d counts checked, %0d nonzero, %0d empty ranges, %0d errors",
               counts_checked, nonzero_counts, empty_queries, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/frc_pkg.sv
rtl/frc_ctrl.sv
rtl/frc_datapath.sv
rtl/fenwick_range_counter_unit.sv
test/tb.sv
